[rtl/clta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clta_pkg
// Shared types and constants of the credit limited tag allocator.
// ----------------------------------------------------------------------------
package clta_pkg;

  localparam int unsigned CREDIT_W = 20;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TAG_W    = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_COMMIT  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_CREDIT  = 2'd1,
    ST_BAD_TAG    = 2'd2,
    ST_SPACE_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

[rtl/clta_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clta_ctrl
// Controller: accepts a command word and steps the datapath through the
// memory read and the execute cycle.
// ----------------------------------------------------------------------------
module clta_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output clta_pkg::ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy        = (state_q == S_EXEC);
  assign ctrl_o.load = start && (state_q == S_IDLE);
  assign ctrl_o.exec = (state_q == S_EXEC);

`ifndef NO_ASSERTIONS
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (state_q == S_IDLE))
    else $error("execute state lasted more than one cycle");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_EXEC))
    else $error("accepted word did not enter execute");
`endif

endmodule

[rtl/clta_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clta_dp
// Datapath: credit and tag counters, free tag stack memory, reserved map
// memory and the result registers.
// ----------------------------------------------------------------------------
module clta_dp #(
  parameter int unsigned TAG_COUNT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  clta_pkg::ctrl_t                ctrl_i,
  input  logic [clta_pkg::CMD_W-1:0]     command_i,
  input  logic [clta_pkg::TAG_W-1:0]     tag_i,
  input  logic                           initial_credit_we_i,
  input  logic [clta_pkg::CREDIT_W-1:0]  initial_credit_i,
  output logic                           done_o,
  output logic [clta_pkg::STATUS_W-1:0]  status_o,
  output logic [clta_pkg::TAG_W-1:0]     granted_tag_o,
  output logic [clta_pkg::CREDIT_W-1:0]  credit_left_o
);

  localparam int unsigned TW   = $clog2(TAG_COUNT);
  localparam int unsigned CW   = $clog2(TAG_COUNT + 1);
  localparam int unsigned CMPW = (CW > clta_pkg::TAG_W) ? CW : clta_pkg::TAG_W;

  logic [clta_pkg::CREDIT_W-1:0] credit_q, credit_d;
  logic [CW-1:0]                 fresh_q, fresh_d;
  logic [CW-1:0]                 depth_q, depth_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          done_q;

  clta_pkg::cmd_e                cmd_q;
  logic [clta_pkg::TAG_W-1:0]    tag_q;
  logic                          map_rd_q;
  logic [TW-1:0]                 stack_rd_q;

  clta_pkg::status_e             status_q, status_d;
  logic [clta_pkg::TAG_W-1:0]    granted_q, granted_d;
  logic [clta_pkg::CREDIT_W-1:0] credit_left_q;

  logic                          map_mem [TAG_COUNT];
  logic [TW-1:0]                 stack_mem [TAG_COUNT];

  logic                          map_we;
  logic [TW-1:0]                 map_waddr;
  logic                          map_wdata;
  logic                          stack_we;
  logic                          tag_reserved;

  // a map entry is defined once its tag has been handed out fresh
  assign tag_reserved = (CMPW'(tag_q) < CMPW'(fresh_q)) && map_rd_q;

  always_comb begin
    logic [TW-1:0] grant;
    logic          ok;
    grant     = '0;
    ok        = 1'b0;
    credit_d  = credit_q;
    fresh_d   = fresh_q;
    depth_d   = depth_q;
    cnt_d     = cnt_q;
    status_d  = clta_pkg::ST_OK;
    granted_d = '0;
    map_we    = 1'b0;
    map_waddr = TW'(tag_q);
    map_wdata = 1'b0;
    stack_we  = 1'b0;
    if (ctrl_i.exec) begin
      unique case (cmd_q)
        clta_pkg::CMD_RESERVE: begin
          if (credit_q == '0 || clta_pkg::CREDIT_W'(cnt_q) >= credit_q) begin
            status_d = clta_pkg::ST_NO_CREDIT;
          end else if (depth_q != '0) begin
            grant   = stack_rd_q;
            depth_d = depth_q - CW'(1);
            ok      = 1'b1;
          end else if (fresh_q < CW'(TAG_COUNT)) begin
            grant   = fresh_q[TW-1:0];
            fresh_d = fresh_q + CW'(1);
            ok      = 1'b1;
          end else begin
            status_d = clta_pkg::ST_SPACE_FULL;
          end
          if (ok) begin
            map_we    = 1'b1;
            map_waddr = grant;
            map_wdata = 1'b1;
            cnt_d     = cnt_q + CW'(1);
            granted_d = clta_pkg::TAG_W'(grant);
          end
        end
        clta_pkg::CMD_FREE, clta_pkg::CMD_COMMIT: begin
          if (!tag_reserved) begin
            status_d = clta_pkg::ST_BAD_TAG;
          end else begin
            if (cmd_q == clta_pkg::CMD_COMMIT && credit_q != '0) begin
              credit_d = credit_q - clta_pkg::CREDIT_W'(1);
            end
            map_we = 1'b1;
            if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
            if (depth_q < CW'(TAG_COUNT)) begin
              stack_we = 1'b1;
              depth_d  = depth_q + CW'(1);
            end
          end
        end
        clta_pkg::CMD_NOP: begin
          status_d = clta_pkg::ST_OK;
        end
        default: begin
          status_d = clta_pkg::ST_OK;
        end
      endcase
    end
    if (initial_credit_we_i) credit_d = initial_credit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      fresh_q  <= '0;
      depth_q  <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      credit_q <= credit_d;
      fresh_q  <= fresh_d;
      depth_q  <= depth_d;
      cnt_q    <= cnt_d;
      done_q   <= ctrl_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= clta_pkg::cmd_e'(command_i);
      tag_q <= tag_i;
    end
    if (ctrl_i.exec) begin
      status_q      <= status_d;
      granted_q     <= granted_d;
      credit_left_q <= credit_d;
    end
  end

  // tag map and free stack, registered read on accept
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      map_rd_q   <= map_mem[TW'(tag_i)];
      stack_rd_q <= stack_mem[TW'(depth_q - CW'(1))];
    end
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (stack_we) stack_mem[depth_q[TW-1:0]] <= TW'(tag_q);
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign granted_tag_o = granted_q;
  assign credit_left_o = credit_left_q;

`ifndef NO_ASSERTIONS
  a_tag_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q + cnt_q) == fresh_q)
    else $error("stacked plus reserved tags differ from used tags");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TAG_COUNT))
    else $error("reserved count above tag space");

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(ctrl_i.exec))
    else $error("result strobe without execute cycle");
`endif

endmodule

[rtl/credit_limited_tag_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_limited_tag_allocator
// Hands out reservation tags against a credit budget, reusing freed tags from a lifo free list before fresh ones.
// ----------------------------------------------------------------------------
// Usage:
//   command channel: drive command_i and tag_i with start high; the word is
//   taken at a rising edge where start is high and busy is low.
//   result channel: done_o is high for exactly one cycle with status_o,
//   granted_tag_o and credit_left_o valid; the receiver cannot stall it.
//   config: initial_credit_we_i high for one edge loads initial_credit_i
//   into the remaining credit; write only while the block is idle.
// Sequence:
//   a word accepted at a rising edge registers its command, tag and the
//   tag map and free stack reads; the execute state follows and its end
//   registers the result with done_o. busy is high for one cycle after each
//   accept, so a new word waits until the previous one has executed.
// Reset:
//   credit, counters and stack depth go to zero, no tag is reserved. Map
//   and stack memories need no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
module credit_limited_tag_allocator #(
  parameter int unsigned TAG_COUNT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [clta_pkg::CMD_W-1:0]     command_i,
  input  logic [clta_pkg::TAG_W-1:0]     tag_i,
  input  logic                           initial_credit_we_i,
  input  logic [clta_pkg::CREDIT_W-1:0]  initial_credit_i,
  output logic                           done_o,
  output logic [clta_pkg::STATUS_W-1:0]  status_o,
  output logic [clta_pkg::TAG_W-1:0]     granted_tag_o,
  output logic [clta_pkg::CREDIT_W-1:0]  credit_left_o
);

  clta_pkg::ctrl_t ctrl;

  clta_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  clta_dp #(
    .TAG_COUNT (TAG_COUNT)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .command_i           (command_i),
    .tag_i               (tag_i),
    .initial_credit_we_i (initial_credit_we_i),
    .initial_credit_i    (initial_credit_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .granted_tag_o       (granted_tag_o),
    .credit_left_o       (credit_left_o)
  );

endmodule

[test/tag_alloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_alloc_checker
// Tracks credit, the free tag stack and the reserved tag map of the allocator
// from the words it accepts and the credit writes it sees. Every result word
// is compared field by field with the oldest predicted answer.
// ----------------------------------------------------------------------------
module tag_alloc_checker
  import clta_pkg::*;
#(
  parameter int unsigned TAG_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [TAG_W-1:0]    tag_i,
  input  logic                credit_we_i,
  input  logic [CREDIT_W-1:0] credit_i,
  input  logic                done_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [TAG_W-1:0]    granted_tag_i,
  input  logic [CREDIT_W-1:0] credit_left_i,
  output int                  fail_count_o,
  output int                  outstanding_o
);

  typedef struct {
    status_e             status;
    logic [TAG_W-1:0]    tag;
    logic [CREDIT_W-1:0] credit;
  } answer_t;

  logic [CREDIT_W-1:0] credit;
  int unsigned         fresh_tag;
  int unsigned         stack_depth;
  int unsigned         held_count;
  logic [TAG_W-1:0]    free_stack [TAG_COUNT];
  bit                  held_map [TAG_COUNT];
  answer_t             answers [$];
  answer_t             oldest;
  int                  mismatches = 0;
  int                  queued = 0;

  assign fail_count_o  = mismatches;
  assign outstanding_o = queued;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic answer_t predict_tag_op(input cmd_e cmd, input logic [TAG_W-1:0] tag);
    answer_t     a;
    int unsigned t;
    a.status = ST_OK;
    a.tag    = '0;
    case (cmd)
      CMD_RESERVE: begin
        if (credit == '0 || held_count >= credit) begin
          a.status = ST_NO_CREDIT;
        end else if (stack_depth == 0 && fresh_tag >= TAG_COUNT) begin
          a.status = ST_SPACE_FULL;
        end else begin
          if (stack_depth > 0) begin
            stack_depth--;
            t = 32'(free_stack[stack_depth]);
          end else begin
            t = fresh_tag;
            fresh_tag++;
          end
          held_map[t] = 1'b1;
          held_count++;
          a.tag = t[TAG_W-1:0];
        end
      end
      CMD_FREE, CMD_COMMIT: begin
        if (tag >= TAG_COUNT || !held_map[tag]) begin
          a.status = ST_BAD_TAG;
        end else begin
          // spending saturates at zero
          if (cmd == CMD_COMMIT && credit != '0) credit--;
          held_map[tag] = 1'b0;
          if (held_count > 0) held_count--;
          if (stack_depth < TAG_COUNT) begin
            free_stack[stack_depth] = tag;
            stack_depth++;
          end
        end
      end
      default: ;
    endcase
    a.credit = credit;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit      = '0;
      fresh_tag   = 0;
      stack_depth = 0;
      held_count  = 0;
      foreach (held_map[i]) held_map[i] = 1'b0;
      answers.delete();
      queued = 0;
    end else begin
      if (done_i) begin
        if (answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result word, status %0d tag %0d credit %0d",
                                    status_i, granted_tag_i, credit_left_i));
        end else begin
          oldest = answers.pop_front();
          if (status_i !== oldest.status)
            report_mismatch($sformatf("status got %0d expected %0d", status_i, oldest.status));
          if (granted_tag_i !== oldest.tag)
            report_mismatch($sformatf("granted tag got %0d expected %0d",
                                      granted_tag_i, oldest.tag));
          if (credit_left_i !== oldest.credit)
            report_mismatch($sformatf("credit left got %0d expected %0d",
                                      credit_left_i, oldest.credit));
        end
      end
      if (start_i && !busy_i) answers.push_back(predict_tag_op(cmd_e'(command_i), tag_i));
      if (credit_we_i) credit = credit_i;
      queued = answers.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the credit limited tag allocator with a directed opening and then
// random reserve, free and commit bursts under several credit budgets, from
// zero up to the full 20-bit range. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import clta_pkg::*;

  localparam int unsigned TAG_COUNT   = 64;
  localparam int          CYCLE_LIMIT = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command;
  logic [TAG_W-1:0]    tag;
  logic                credit_we;
  logic [CREDIT_W-1:0] credit_val;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    granted_tag;
  logic [CREDIT_W-1:0] credit_left;

  int               fail_count;
  int               outstanding;
  int               cycle_count = 0;
  cmd_e             sent_cmds [$];
  logic [TAG_W-1:0] live_tags [$];
  cmd_e             done_cmd;

  credit_limited_tag_allocator #(.TAG_COUNT(TAG_COUNT)) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .command_i           (command),
    .tag_i               (tag),
    .initial_credit_we_i (credit_we),
    .initial_credit_i    (credit_val),
    .done_o              (done),
    .status_o            (status),
    .granted_tag_o       (granted_tag),
    .credit_left_o       (credit_left)
  );

  tag_alloc_checker #(.TAG_COUNT(TAG_COUNT)) alloc_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .command_i     (command),
    .tag_i         (tag),
    .credit_we_i   (credit_we),
    .credit_i      (credit_val),
    .done_i        (done),
    .status_i      (status),
    .granted_tag_i (granted_tag),
    .credit_left_i (credit_left),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // granted tags feed the free and commit stimulus
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done && sent_cmds.size() > 0) begin
        done_cmd = sent_cmds.pop_front();
        if (done_cmd == CMD_RESERVE && status == ST_OK) live_tags.push_back(granted_tag);
      end
      if (start && !busy) sent_cmds.push_back(cmd_e'(command));
    end
  end

  task automatic send_word(input cmd_e c, input logic [TAG_W-1:0] t);
    @(negedge clk_i);
    start   <= 1'b1;
    command <= c;
    tag     <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_credit(input logic [CREDIT_W-1:0] v);
    drain();
    repeat (3) @(negedge clk_i);
    credit_we  <= 1'b1;
    credit_val <= v;
    @(negedge clk_i);
    credit_we  <= 1'b0;
  endtask

  task automatic issue_random(input int reserve_pct);
    int               r;
    int               idx;
    logic [TAG_W-1:0] t;
    cmd_e             c;
    r = $urandom_range(0, 99);
    t = TAG_W'($urandom_range(0, TAG_COUNT - 1));
    if (r < reserve_pct) begin
      c = CMD_RESERVE;
    end else begin
      r = $urandom_range(0, 9);
      c = ($urandom_range(0, 1) != 0) ? CMD_COMMIT : CMD_FREE;
      if (r < 7 && live_tags.size() > 0) begin
        idx = $urandom_range(0, live_tags.size() - 1);
        t   = live_tags[idx];
        live_tags.delete(idx);
      end else if (r == 9) begin
        c = CMD_NOP;
      end
    end
    send_word(c, t);
  endtask

  task automatic run_phase(input logic [CREDIT_W-1:0] v, input int n, input int reserve_pct);
    int sent;
    int burst;
    write_credit(v);
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        issue_random(reserve_pct);
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        9:       drain();
        default: idle_for($urandom_range(1, 6));
      endcase
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    command    = CMD_NOP;
    tag        = '0;
    credit_we  = 1'b0;
    credit_val = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero credit after reset, unknown tags, unused command
    send_word(CMD_RESERVE, 6'd0);
    send_word(CMD_FREE, 6'd0);
    send_word(CMD_COMMIT, 6'd63);
    send_word(CMD_NOP, 6'd63);
    send_word(CMD_NOP, 6'd0);

    // quota full, lifo reuse, unknown tag
    write_credit(20'd3);
    send_word(CMD_RESERVE, 6'd63);
    send_word(CMD_RESERVE, 6'd63);
    send_word(CMD_RESERVE, 6'd63);
    send_word(CMD_RESERVE, 6'd21);
    send_word(CMD_FREE, 6'd1);
    send_word(CMD_COMMIT, 6'd0);
    send_word(CMD_RESERVE, 6'd0);
    send_word(CMD_FREE, 6'd42);

    // credit lowered below outstanding tags
    write_credit(20'd1);
    send_word(CMD_RESERVE, 6'd0);

    // commit with zero credit left
    write_credit(20'd0);
    send_word(CMD_COMMIT, 6'd2);
    send_word(CMD_COMMIT, 6'd0);
    send_word(CMD_FREE, 6'd2);
    drain();
    live_tags.delete();

    run_phase(20'hFFFFF, 130, 90);
    run_phase(20'd5, 80, 50);
    run_phase(20'd64, 100, 55);
    repeat (3) run_phase(CREDIT_W'($urandom_range(1, 80)), 70, 50);
    run_phase(20'd0, 40, 30);
    run_phase(20'hFFFFF, 110, 60);

    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
